FILE: src/fars_pkg.sv
// shared types and constants for the fault-aware round-robin selector
package fars_pkg;

	localparam int unsigned KIND_W = 2;
	localparam int unsigned IDX_W  = 4;
	localparam int unsigned CNT_W  = 5;

	localparam logic [KIND_W-1:0] KIND_CHOOSE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FAIL   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_OK     = 2'd2;

	typedef struct packed {
		logic load_item;
		logic exec;
		logic scan_step;
		logic rot_write;
		logic rm_step;
		logic rm_end;
		logic load_result;
	} cmd_t;

	typedef struct packed {
		logic is_choose;
		logic rm_needed;
		logic scan_retry;
		logic scan_hit;
		logic scan_last;
		logic rm_busy;
		logic out_free;
	} sts_t;

endpackage

FILE: src/fault_aware_round_robin_selector_top.sv
// top level of the fault-aware round-robin selector
//
// input transfer: kind and node_index under in_valid / in_stall. kind 0 picks
// the next healthy node round-robin, kind 1 reports a node failed, kind 2
// reports it recovered. each transfer gives exactly one result transfer of
// chosen_node, is_retry and status under out_valid / out_stall, in order.
// the user must write node_count through cfg_we / cfg_data only while the
// block is idle; the block does not enforce it. one item is worked on at a
// time; in_stall is low only in the idle state. controller steps after load and exec:
//   report or unknown kind: straight to the done state
//   choose: scan 1 .. effective node count + 1 positions, one per cycle
//   retry from the fault queue: scan to the wrap, move the queue head to the back
//   recovery: one queue entry read per cycle to compact it
// the next item is taken in the cycle after the result is loaded, even while
// the result still waits in the output register under out_stall; a second
// result waits in the controller until that register is free.
// reset clears the fault marks, queue pointers and scan position and sets
// node_count to 1; queue contents need no clearing.
module fault_aware_round_robin_selector_top #(
	parameter int unsigned MAX_NODES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [fars_pkg::CNT_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [fars_pkg::KIND_W-1:0] kind,
	input  logic [fars_pkg::IDX_W-1:0]  node_index,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [fars_pkg::IDX_W-1:0]  chosen_node,
	output logic                        is_retry,
	output logic                        status
);
	import fars_pkg::*;

	cmd_t cmd;
	sts_t sts;

	fars_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	fars_datapath #(
		.MAX_NODES (MAX_NODES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.kind        (kind),
		.node_index  (node_index),
		.out_stall   (out_stall),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.chosen_node (chosen_node),
		.is_retry    (is_retry),
		.status      (status)
	);

endmodule

FILE: src/fars_ctrl.sv
// controller state machine for the fault-aware round-robin selector
module fars_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  fars_pkg::sts_t sts,
	output fars_pkg::cmd_t cmd
);
	import fars_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_EXEC   = 7'b0000010,
		ST_SCAN   = 7'b0000100,
		ST_ROT_RD = 7'b0001000,
		ST_ROT_WR = 7'b0010000,
		ST_RM     = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.is_choose) begin
					state_d = ST_SCAN;
				end else if (sts.rm_needed) begin
					state_d = ST_RM;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_retry) begin
					state_d = ST_ROT_RD;
				end else if (sts.scan_hit || sts.scan_last) begin
					state_d = ST_DONE;
				end
			end
			ST_ROT_RD: begin
				state_d = ST_ROT_WR;
			end
			ST_ROT_WR: begin
				cmd.rot_write = 1'b1;
				state_d       = ST_DONE;
			end
			ST_RM: begin
				cmd.rm_step = 1'b1;
				if (!sts.rm_busy) begin
					cmd.rm_end = 1'b1;
					state_d    = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_result = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: src/fars_datapath.sv
// datapath: fault marks, fault queue memory, scan position and result register
module fars_datapath #(
	parameter int unsigned MAX_NODES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fars_pkg::CNT_W-1:0]    cfg_data,
	input  logic [fars_pkg::KIND_W-1:0]   kind,
	input  logic [fars_pkg::IDX_W-1:0]    node_index,
	input  logic                          out_stall,
	input  fars_pkg::cmd_t                cmd,
	output fars_pkg::sts_t                sts,
	output logic                          out_valid,
	output logic [fars_pkg::IDX_W-1:0]    chosen_node,
	output logic                          is_retry,
	output logic                          status
);
	import fars_pkg::*;

	localparam int unsigned AW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int unsigned CW   = $clog2(MAX_NODES + 1);
	localparam int unsigned SW   = AW + 1;
	localparam int unsigned XW   = (AW > CNT_W) ? AW : CNT_W;
	localparam int unsigned MAXC = (MAX_NODES < 31) ? MAX_NODES : 31;
	localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAXC);

	function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [CW-1:0] b);
		logic [SW-1:0] s;
		s = SW'(a) + SW'(b);
		if (s >= SW'(MAX_NODES)) begin
			s = s - SW'(MAX_NODES);
		end
		return s[AW-1:0];
	endfunction

	logic [CNT_W-1:0]     node_count_q;
	logic [CNT_W-1:0]     n;
	logic [MAX_NODES-1:0] marks_q;
	logic [CNT_W-1:0]     pos_q;
	logic [CNT_W-1:0]     iter_q;
	logic [AW-1:0]        head_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        rm_i_q;
	logic [CW-1:0]        rm_k_q;
	logic                 rm_pend_q;
	logic                 out_valid_q;

	logic [KIND_W-1:0]    kind_q;
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     res_chosen_q;
	logic                 res_retry_q;
	logic                 res_status_q;
	logic [IDX_W-1:0]     out_chosen_q;
	logic                 out_retry_q;
	logic                 out_status_q;

	logic [IDX_W-1:0]     mem [MAX_NODES];
	logic [IDX_W-1:0]     rd_q;
	logic                 mem_we;
	logic [AW-1:0]        mem_wa;
	logic [IDX_W-1:0]     mem_wd;
	logic [AW-1:0]        mem_ra;

	logic                 idx_bad;
	logic [XW-1:0]        idx_x;
	logic                 mark_i;
	logic                 wrap;
	logic [CNT_W-1:0]     p;
	logic [XW-1:0]        p_x;
	logic                 mark_p;
	logic                 push_ok;
	logic                 do_push;
	logic                 is_report;

	// effective node count, clamped to 1..max
	always_comb begin
		if (node_count_q == '0) begin
			n = CNT_W'(1);
		end else if (node_count_q > MAX_N) begin
			n = MAX_N;
		end else begin
			n = node_count_q;
		end
	end

	assign idx_bad   = ({1'b0, idx_q} >= n);
	assign idx_x     = XW'(idx_q);
	assign mark_i    = marks_q[idx_x[AW-1:0]];
	assign is_report = (kind_q == KIND_FAIL) || (kind_q == KIND_OK);
	assign push_ok   = (count_q < CW'(MAX_NODES));
	assign do_push   = cmd.exec && (kind_q == KIND_FAIL) && !idx_bad && !mark_i && push_ok;

	assign wrap   = (pos_q >= n);
	assign p      = wrap ? '0 : pos_q;
	assign p_x    = XW'(p);
	assign mark_p = marks_q[p_x[AW-1:0]];

	always_comb begin
		sts            = '0;
		sts.is_choose  = (kind_q == KIND_CHOOSE);
		sts.rm_needed  = (kind_q == KIND_OK) && !idx_bad && mark_i;
		sts.scan_retry = wrap && (count_q != '0);
		sts.scan_hit   = !sts.scan_retry && !mark_p;
		sts.scan_last  = !sts.scan_retry && mark_p && (iter_q == n);
		sts.rm_busy    = (rm_i_q != count_q) || rm_pend_q;
		sts.out_free   = !out_valid_q || !out_stall;
	end

	// single write port, single registered read port
	always_comb begin
		mem_we = 1'b0;
		mem_wa = wrap_add(head_q, count_q);
		mem_wd = idx_q;
		priority if (cmd.rot_write) begin
			mem_we = 1'b1;
			mem_wd = rd_q;
		end else if (do_push) begin
			mem_we = 1'b1;
		end else if (cmd.rm_step && rm_pend_q && (rd_q != idx_q)) begin
			mem_we = 1'b1;
			mem_wa = wrap_add(head_q, rm_k_q);
			mem_wd = rd_q;
		end else begin
			mem_we = 1'b0;
		end
	end

	assign mem_ra = cmd.rm_step ? wrap_add(head_q, rm_i_q) : head_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CNT_W'(1);
			marks_q      <= '0;
			pos_q        <= '0;
			iter_q       <= '0;
			head_q       <= '0;
			count_q      <= '0;
			rm_i_q       <= '0;
			rm_k_q       <= '0;
			rm_pend_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				node_count_q <= cfg_data;
			end
			if (cmd.load_item) begin
				iter_q <= '0;
			end
			if (cmd.exec && is_report && !idx_bad) begin
				if ((kind_q == KIND_FAIL) && !mark_i) begin
					marks_q[idx_x[AW-1:0]] <= 1'b1;
					if (push_ok) begin
						count_q <= count_q + CW'(1);
					end
				end else if ((kind_q == KIND_OK) && mark_i) begin
					marks_q[idx_x[AW-1:0]] <= 1'b0;
					rm_i_q    <= '0;
					rm_k_q    <= '0;
					rm_pend_q <= 1'b0;
				end
			end
			if (cmd.scan_step) begin
				if (sts.scan_retry) begin
					pos_q <= '0;
				end else begin
					pos_q <= p + CNT_W'(1);
					if (mark_p && (iter_q != n)) begin
						iter_q <= iter_q + CNT_W'(1);
					end
				end
			end
			if (cmd.rot_write) begin
				head_q <= wrap_add(head_q, CW'(1));
			end
			if (cmd.rm_step) begin
				if (rm_i_q != count_q) begin
					rm_i_q    <= rm_i_q + CW'(1);
					rm_pend_q <= 1'b1;
				end else begin
					rm_pend_q <= 1'b0;
				end
				if (rm_pend_q && (rd_q != idx_q)) begin
					rm_k_q <= rm_k_q + CW'(1);
				end
			end
			if (cmd.rm_end) begin
				count_q <= rm_k_q;
			end
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q       <= kind;
			idx_q        <= node_index;
			res_chosen_q <= '0;
			res_retry_q  <= 1'b0;
			res_status_q <= 1'b0;
		end
		if (cmd.exec && is_report && idx_bad) begin
			res_status_q <= 1'b1;
		end
		if (cmd.scan_step && !sts.scan_retry) begin
			if (!mark_p) begin
				res_chosen_q <= p[IDX_W-1:0];
			end else if (iter_q == n) begin
				res_status_q <= 1'b1;
			end
		end
		if (cmd.rot_write) begin
			res_chosen_q <= rd_q;
			res_retry_q  <= 1'b1;
		end
		if (cmd.load_result) begin
			out_chosen_q <= res_chosen_q;
			out_retry_q  <= res_retry_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign chosen_node = out_chosen_q;
	assign is_retry    = out_retry_q;
	assign status      = out_status_q;

endmodule

FILE: tb/tb.sv
// self-checking testbench for the fault-aware round-robin selector top level
`timescale 1ns / 1ps

module tb;
	import fars_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;
	localparam int NODES_MAX   = 16;
	localparam int QUIET_LIMIT = 3000;

	typedef struct packed {
		logic [IDX_W-1:0] chosen;
		logic             retry;
		logic             status;
	} outcome_t;

	typedef struct packed {
		logic              is_cfg;
		logic [CNT_W-1:0]  cfg;
		logic [KIND_W-1:0] k;
		logic [IDX_W-1:0]  idx;
		logic              typed;
		outcome_t          want;
	} step_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CNT_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [KIND_W-1:0] kind = '0;
	logic [IDX_W-1:0]  node_index = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [IDX_W-1:0]  chosen_node;
	logic              is_retry;
	logic              status;

	// mirror of the selector state
	logic             fault_mark [NODES_MAX] = '{default: 1'b0};
	logic [IDX_W-1:0] retry_fifo [NODES_MAX] = '{default: '0};
	logic [CNT_W-1:0] scan_pos = '0;
	logic [IDX_W-1:0] fifo_rd = '0;
	logic [CNT_W-1:0] fifo_fill = '0;
	logic [CNT_W-1:0] nodes_cfg = 5'd1;

	outcome_t outcomes_due [$];
	step_t    script [$];

	int errors = 0;
	int kinds_sent [4] = '{default: 0};
	int retries_seen = 0;
	int rejects_seen = 0;
	int cfg_writes = 0;
	int quiet_cycles = 0;
	logic [7:0] stall_phase = '0;
	int stall_run = 0;

	fault_aware_round_robin_selector_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.node_index (node_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.chosen_node(chosen_node),
		.is_retry   (is_retry),
		.status     (status)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int active_nodes();
		if (nodes_cfg == 0)
			return 1;
		if (nodes_cfg > NODES_MAX)
			return NODES_MAX;
		return int'(nodes_cfg);
	endfunction

	task automatic selector_outcome(input logic [KIND_W-1:0] k, input logic [IDX_W-1:0] idx,
			output outcome_t o);
		int n;
		int p;
		int m;
		bit found;
		logic [IDX_W-1:0] v;
		logic [IDX_W-1:0] kept [NODES_MAX];
		o = '0;
		n = active_nodes();
		case (k)
			KIND_CHOOSE: begin
				found = 1'b0;
				for (int i = 0; i <= n && !found; i++) begin
					if (scan_pos >= n) begin
						scan_pos = '0;
						if (fifo_fill != 0) begin
							// oldest faulty node goes to the back and is retried
							v = retry_fifo[fifo_rd];
							fifo_rd = fifo_rd + 1'b1;
							retry_fifo[4'(fifo_rd + fifo_fill - 5'd1)] = v;
							o.chosen = v;
							o.retry = 1'b1;
							found = 1'b1;
						end
					end
					if (!found) begin
						p = int'(scan_pos);
						scan_pos = scan_pos + 1'b1;
						if (!fault_mark[p]) begin
							o.chosen = IDX_W'(p);
							found = 1'b1;
						end
					end
				end
				if (!found)
					o.status = STATUS_BAD;
			end
			KIND_FAIL, KIND_OK: begin
				if (idx >= n) begin
					o.status = STATUS_BAD;
				end else if (k == KIND_FAIL) begin
					if (!fault_mark[idx] ) begin
						fault_mark[idx] = 1'b1;
						if (fifo_fill < NODES_MAX) begin
							retry_fifo[4'(fifo_rd + fifo_fill)] = idx;
							fifo_fill = fifo_fill + 1'b1;
						end
					end
				end else if (fault_mark[idx]) begin
					// drop the node from the queue, rest keep their order
					fault_mark[idx] = 1'b0;
					m = 0;
					for (int i = 0; i < fifo_fill; i++) begin
						if (retry_fifo[4'(fifo_rd + i)] != idx) begin
							kept[m] = retry_fifo[4'(fifo_rd + i)];
							m++;
						end
					end
					for (int i = 0; i < m; i++)
						retry_fifo[4'(fifo_rd + i)] = kept[i];
					fifo_fill = CNT_W'(m);
				end
			end
			default: ;
		endcase
	endtask

	function automatic step_t cfg_row(input logic [CNT_W-1:0] v);
		step_t s;
		s = '0;
		s.is_cfg = 1'b1;
		s.cfg = v;
		return s;
	endfunction

	function automatic step_t item_row(input logic [KIND_W-1:0] k, input logic [IDX_W-1:0] idx);
		step_t s;
		s = '0;
		s.k = k;
		s.idx = idx;
		return s;
	endfunction

	function automatic step_t known_row(input logic [KIND_W-1:0] k, input logic [IDX_W-1:0] idx,
			input logic [IDX_W-1:0] chosen, input logic retry, input logic st);
		step_t s;
		s = item_row(k, idx);
		s.typed = 1'b1;
		s.want.chosen = chosen;
		s.want.retry = retry;
		s.want.status = st;
		return s;
	endfunction

	// holds the transfer until taken, valid stays high for the caller to decide
	task automatic send_item(input logic [KIND_W-1:0] k, input logic [IDX_W-1:0] idx,
			input logic typed, input outcome_t want);
		outcome_t predicted;
		in_valid <= 1'b1;
		kind <= k;
		node_index <= idx;
		do
			@(posedge clk);
		while (in_stall);
		selector_outcome(k, idx, predicted);
		outcomes_due.push_back(typed ? want : predicted);
		kinds_sent[k]++;
	endtask

	task automatic write_node_count(input logic [CNT_W-1:0] v);
		in_valid <= 1'b0;
		while (outcomes_due.size() != 0 || in_stall)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		nodes_cfg = v;
		cfg_writes++;
	endtask

	task automatic check_field(input string what, input logic [IDX_W-1:0] want,
			input logic [IDX_W-1:0] got);
		if (got !== want) begin
			$display("%0t %s expected %0d got %0d", $time, what, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (outcomes_due.size() == 0) begin
				$display("%0t result transfer with none pending: chosen_node %0d is_retry %0d status %0d",
					$time, chosen_node, is_retry, status);
				errors++;
			end else begin
				want = outcomes_due.pop_front();
				check_field("chosen_node", want.chosen, chosen_node);
				check_field("is_retry", IDX_W'(want.retry), IDX_W'(is_retry));
				check_field("status", IDX_W'(want.status), IDX_W'(status));
				if (want.retry)
					retries_seen++;
				if (want.status == STATUS_BAD)
					rejects_seen++;
			end
		end
	end

	// receiver stall modes rotate with the upper bits of stall_phase, runs capped
	always @(posedge clk) begin : result_stall
		logic stall_wish;
		case (stall_phase[7:6])
			2'd0: stall_wish = 1'b0;
			2'd1: stall_wish = $urandom_range(0, 1) == 1;
			2'd2: stall_wish = $urandom_range(0, 4) != 0;
			default: stall_wish = stall_phase[2:0] < 3'd3;
		endcase
		if (stall_run >= 10)
			stall_wish = 1'b0;
		out_stall <= stall_wish;
		stall_run <= stall_wish ? stall_run + 1 : 0;
		stall_phase <= stall_phase + 1'b1;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t no transfer for %0d cycles", $time, QUIET_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [CNT_W-1:0] setting;
		logic [KIND_W-1:0] k;
		logic [IDX_W-1:0] idx;
		int items_left;
		int burst;
		int pick;
		int eff;

		script = '{
			known_row(KIND_CHOOSE, 4'd0, 4'd0, 1'b0, STATUS_OK),
			known_row(KIND_CHOOSE, 4'd0, 4'd0, 1'b0, STATUS_OK),
			known_row(KIND_FAIL, 4'd15, 4'd0, 1'b0, STATUS_BAD),
			known_row(KIND_OK, 4'd1, 4'd0, 1'b0, STATUS_BAD),
			known_row(KIND_UNKNOWN, 4'd15, 4'd0, 1'b0, STATUS_OK),
			known_row(KIND_FAIL, 4'd0, 4'd0, 1'b0, STATUS_OK),
			known_row(KIND_CHOOSE, 4'd9, 4'd0, 1'b1, STATUS_OK),
			known_row(KIND_FAIL, 4'd0, 4'd0, 1'b0, STATUS_OK),
			cfg_row(5'd16),
			item_row(KIND_CHOOSE, 4'd15),
			item_row(KIND_FAIL, 4'd15),
			item_row(KIND_FAIL, 4'd7),
			item_row(KIND_OK, 4'd0),
			item_row(KIND_OK, 4'd3),
			item_row(KIND_FAIL, 4'd15),
			item_row(KIND_CHOOSE, 4'd0),
			item_row(KIND_CHOOSE, 4'd0),
			item_row(KIND_CHOOSE, 4'd0),
			// shrink below the queued node: stale retry and position wrap
			cfg_row(5'd4),
			item_row(KIND_CHOOSE, 4'd0),
			item_row(KIND_CHOOSE, 4'd0),
			known_row(KIND_FAIL, 4'd4, 4'd0, 1'b0, STATUS_BAD),
			cfg_row(5'd0),
			item_row(KIND_CHOOSE, 4'd0),
			known_row(KIND_FAIL, 4'd1, 4'd0, 1'b0, STATUS_BAD),
			cfg_row(5'd31),
			item_row(KIND_OK, 4'd15),
			item_row(KIND_CHOOSE, 4'd15),
			item_row(KIND_OK, 4'd7)
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[r]) begin
			if (script[r].is_cfg)
				write_node_count(script[r].cfg);
			else
				send_item(script[r].k, script[r].idx, script[r].typed, script[r].want);
		end

		repeat (12) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0: setting = 5'd0;
				1: setting = 5'd1;
				2: setting = 5'd16;
				3: setting = 5'd31;
				4: setting = CNT_W'($urandom_range(17, 30));
				default: setting = CNT_W'($urandom_range(2, 15));
			endcase
			write_node_count(setting);
			eff = active_nodes();
			items_left = $urandom_range(60, 140);
			while (items_left > 0) begin
				burst = $urandom_range(1, 24);
				for (int b = 0; b < burst && items_left > 0; b++) begin
					pick = $urandom_range(0, 99);
					k = pick < 45 ? KIND_CHOOSE : pick < 70 ? KIND_FAIL :
						pick < 95 ? KIND_OK : KIND_UNKNOWN;
					if ($urandom_range(0, 9) == 0)
						idx = IDX_W'($urandom);
					else
						idx = IDX_W'($urandom_range(0, eff - 1));
					send_item(k, idx, 1'b0, '0);
					if (k != KIND_UNKNOWN)
						items_left--;
				end
				if ($urandom_range(0, 3) != 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 8)) @(posedge clk);
				end
			end
		end

		in_valid <= 1'b0;
		while (outcomes_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("covered %0d picks, %0d failure and %0d recovery reports, %0d unknown kinds",
			kinds_sent[KIND_CHOOSE], kinds_sent[KIND_FAIL], kinds_sent[KIND_OK],
			kinds_sent[KIND_UNKNOWN]);
		$display("%0d retries from the fault queue, %0d rejected reports, %0d node_count writes",
			retries_seen, rejects_seen, cfg_writes);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
